[rtl/sdwa_pkg.sv]
// Shared types and constants for the spike-driven weight accumulator.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package sdwa_pkg;

   // Fixed field widths
   localparam int ID_W   = 10;
   localparam int DVS_W  = 7;
   localparam int WORD_W = 32;
   localparam int DIV_CNT_W = $clog2(ID_W + 1);

   // Item function codes
   localparam logic [1:0] FUNC_WRITE_WEIGHT = 2'd0;
   localparam logic [1:0] FUNC_CLEAR        = 2'd1;
   localparam logic [1:0] FUNC_SPIKE        = 2'd2;
   localparam logic [1:0] FUNC_READ         = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_DONE        = 2'd0;
   localparam logic [1:0] STATUS_COL_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_ROW_DROPPED = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_INPUT_WIDTH      = 2'd0;
   localparam logic [1:0] CSR_WEIGHT_ROWS_USED = 2'd1;
   localparam logic [1:0] CSR_WEIGHT_COLS_USED = 2'd2;
   localparam logic [1:0] CSR_OUTPUT_ROWS_USED = 2'd3;

   typedef struct packed {
      logic [1:0]               func;
      logic [ID_W-1:0]          spike_src;
      logic [5:0]               weight_row;
      logic [3:0]               weight_col;
      logic signed [WORD_W-1:0] weight_value;
      logic [3:0]               read_row;
      logic [3:0]               read_col;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] acc_value;
      logic [1:0]               status;
   } rsp_type;

   // Sequencer to store controls
   typedef struct packed {
      logic wt_we;       // write one weight word
      logic acc_rd;      // read one accumulator word
      logic step;        // accumulate step: read the weight word, write the sum next cycle
      logic use_weight;  // add the weight word, else add zero
      logic keep_old;    // add onto the stored word, else onto zero
   } store_ctl_type;

endpackage

`default_nettype wire

[rtl/sdwa_div.sv]
// Iterative restoring divider: one quotient bit per cycle through a shared subtractor.
// Depends on sdwa_pkg.
`default_nettype none

module sdwa_div
   import sdwa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ID_W-1:0]  dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [ID_W-1:0]       quotient,
   output logic [DVS_W-1:0]      remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [ID_W-1:0]      quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W+1:0]     diff;

   // trial subtract of the divisor from the partial remainder with the next bit in
   assign diff = {1'b0, rem_ff, quo_ff[ID_W-1]} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(ID_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // keep the difference only when it did not borrow
         if (!diff[DVS_W+1]) begin
            rem_in = diff[DVS_W-1:0];
         end else begin
            rem_in = {rem_ff[DVS_W-2:0], quo_ff[ID_W-1]};
         end
         quo_in = {quo_ff[ID_W-2:0], ~diff[DVS_W+1]};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/sdwa_store.sv]
// Weight memory, accumulator memory and the shared 32-bit adder of the accumulate loop.
// Depends on sdwa_pkg; driven by the sequencer in the top level.
`default_nettype none

module sdwa_store
   import sdwa_pkg::*;
#(
   parameter int WAW    = 10,
   parameter int AAW    = 8,
   parameter int WDEPTH = 1024,
   parameter int ADEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire store_ctl_type     ctl,
   input  wire logic [WAW-1:0]    wt_waddr,
   input  wire logic [WORD_W-1:0] wt_wdata,
   input  wire logic [WAW-1:0]    wt_raddr,
   input  wire logic [AAW-1:0]    acc_raddr,
   output logic [WORD_W-1:0]      acc_q
);

   logic [WORD_W-1:0] wt_mem  [WDEPTH];
   logic [WORD_W-1:0] acc_mem [ADEPTH];

   logic [WORD_W-1:0] wt_q_ff;
   logic [WORD_W-1:0] acc_q_ff;
   logic              step_ff;
   logic [AAW-1:0]    waddr_ff;
   logic              use_w_ff;
   logic              keep_ff;
   logic [WORD_W-1:0] sum_in;

   always_ff @(posedge clock) begin
      if (ctl.wt_we) begin
         wt_mem[wt_waddr] <= wt_wdata;
      end
      if (ctl.step) begin
         wt_q_ff <= wt_mem[wt_raddr];
      end
   end

   // wrapping add; weight words beyond the used columns are masked to zero
   always_comb begin
      sum_in = (keep_ff ? acc_q_ff : '0) + (use_w_ff ? wt_q_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (ctl.acc_rd) begin
         acc_q_ff <= acc_mem[acc_raddr];
      end
      if (step_ff) begin
         acc_mem[waddr_ff] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
      end else begin
         step_ff <= ctl.step;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff <= acc_raddr;
      use_w_ff <= ctl.use_weight;
      keep_ff  <= ctl.keep_old;
   end

   assign acc_q = acc_q_ff;

endmodule

`default_nettype wire

[rtl/spike_driven_weight_accumulator.sv]
// Top level of the spike-driven weight accumulator: sequencer, configuration and row flags.
// Depends on sdwa_pkg, sdwa_div and sdwa_store.
//
//   Channel   Ports                                 Transfer when
//   item      start, busy, req_payload             start high and busy low at the edge
//   result    rsp_done, rsp_payload                every cycle rsp_done is high
//   config    csr_we, csr_index, csr_wdata         csr_we high at the edge
//
// A weight write or a clear ends with its transfer; an accumulator read then fetches the
// stored word. A spike passes the transfer, the bit-serial divider that splits the source
// id, a bounds check, then the shared adder over N accumulator words, one word per step,
// and a drain of the last write. N is weight_cols_used capped at MAX_COLS, or MAX_COLS on
// the first spike into a row after reset or a clear (the rest of that row is zeroed on the
// way). A spike that is ignored or dropped, or adds no columns to a row in use, ends at the
// bounds check. Each item gives one result in the cycle after its last step, and busy falls
// in the same cycle. Reset is synchronous, clears the sequencer and the row flags and sets
// the configuration to its defaults; the receiver cannot stall results.
`default_nettype none

module spike_driven_weight_accumulator
   import sdwa_pkg::*;
#(
   parameter int MAX_WEIGHT_ROWS = 64,
   parameter int MAX_COLS        = 16,
   parameter int MAX_OUT_ROWS    = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_payload,
   output logic            rsp_done,
   output rsp_type         rsp_payload,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata
);

   localparam int WDEPTH = MAX_WEIGHT_ROWS * MAX_COLS;
   localparam int ADEPTH = MAX_OUT_ROWS * MAX_COLS;
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
   localparam int ORW    = (MAX_OUT_ROWS > 1) ? $clog2(MAX_OUT_ROWS) : 1;
   localparam int CNW    = $clog2(MAX_COLS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_RDATA = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [6:0]              iw_ff, iw_in;
   logic [6:0]              wrows_ff, wrows_in;
   logic [4:0]              wcols_ff, wcols_in;
   logic [4:0]              orows_ff, orows_in;
   logic [MAX_OUT_ROWS-1:0] row_valid_ff, row_valid_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [AAW-1:0]          abase_ff, abase_in;
   logic [WAW-1:0]          wbase_ff, wbase_in;
   logic [CNW-1:0]          j_ff, j_in;
   logic [CNW-1:0]          n_ff, n_in;
   logic [4:0]              ncols_ff, ncols_in;
   logic                    keep_ff, keep_in;
   logic                    rsp_done_ff, rsp_done_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic [DVS_W-1:0]        divisor;
   logic [6:0]              wrows_cap;
   logic [4:0]              orows_cap;
   logic [4:0]              ncols_cap;
   logic                    div_done;
   logic [ID_W-1:0]         div_quo;
   logic [DVS_W-1:0]        div_rem;
   logic [ORW-1:0]          spike_row;
   logic                    row_hit;
   logic                    w_ok;
   logic [AAW-1:0]          rd_addr;
   store_ctl_type           ctl;
   logic [WAW-1:0]          wt_waddr;
   logic [WAW-1:0]          wt_raddr;
   logic [AAW-1:0]          acc_raddr;
   logic [WORD_W-1:0]       acc_q;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // an input width of zero splits as if it were one
   assign divisor = (iw_ff == 7'd0) ? 7'd1 : iw_ff;

   // clamp the used sizes to the array
   assign wrows_cap = (int'(wrows_ff) > MAX_WEIGHT_ROWS) ? 7'(MAX_WEIGHT_ROWS) : wrows_ff;
   assign orows_cap = (int'(orows_ff) > MAX_OUT_ROWS) ? 5'(MAX_OUT_ROWS) : orows_ff;
   assign ncols_cap = (int'(wcols_ff) > MAX_COLS) ? 5'(MAX_COLS) : wcols_ff;

   assign spike_row = ORW'(div_quo);
   assign row_hit   = row_valid_ff[spike_row];

   // weight writes outside the store are dropped silently
   assign w_ok = (int'(req_payload.weight_row) < MAX_WEIGHT_ROWS)
              && (int'(req_payload.weight_col) < MAX_COLS);
   assign wt_waddr = WAW'(int'(req_payload.weight_row) * MAX_COLS
                        + int'(req_payload.weight_col));
   assign rd_addr  = AAW'(int'(req_payload.read_row) * MAX_COLS
                        + int'(req_payload.read_col));

   assign wt_raddr  = wbase_ff + WAW'(j_ff);
   assign acc_raddr = (state_ff == S_ACC) ? (abase_ff + AAW'(j_ff)) : rd_addr;

   always_comb begin
      ctl.wt_we      = accept && (req_payload.func == FUNC_WRITE_WEIGHT) && w_ok;
      ctl.acc_rd     = (accept && (req_payload.func == FUNC_READ)) || (state_ff == S_ACC);
      ctl.step       = (state_ff == S_ACC);
      ctl.use_weight = (int'(j_ff) < int'(ncols_ff));
      ctl.keep_old   = keep_ff;
   end

   sdwa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && (req_payload.func == FUNC_SPIKE)),
      .dividend  (req_payload.spike_src),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   sdwa_store #(
      .WAW    (WAW),
      .AAW    (AAW),
      .WDEPTH (WDEPTH),
      .ADEPTH (ADEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wt_waddr  (wt_waddr),
      .wt_wdata  (req_payload.weight_value),
      .wt_raddr  (wt_raddr),
      .acc_raddr (acc_raddr),
      .acc_q     (acc_q)
   );

   always_comb begin
      state_in     = state_ff;
      iw_in        = iw_ff;
      wrows_in     = wrows_ff;
      wcols_in     = wcols_ff;
      orows_in     = orows_ff;
      row_valid_in = row_valid_ff;
      rd_ok_in     = rd_ok_ff;
      abase_in     = abase_ff;
      wbase_in     = wbase_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      ncols_in     = ncols_ff;
      keep_in      = keep_ff;
      rsp_done_in  = 1'b0;
      rsp_in       = rsp_ff;

      // the user must write the registers only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_INPUT_WIDTH:      iw_in    = csr_wdata;
            CSR_WEIGHT_ROWS_USED: wrows_in = csr_wdata;
            CSR_WEIGHT_COLS_USED: wcols_in = csr_wdata[4:0];
            CSR_OUTPUT_ROWS_USED: orows_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.acc_value = '0;
               rsp_in.status    = STATUS_DONE;
               case (req_payload.func)
                  FUNC_WRITE_WEIGHT: begin
                     // the store takes the word at this edge
                     rsp_done_in = 1'b1;
                  end
                  FUNC_CLEAR: begin
                     // drop every row flag: unflagged rows read as zero
                     row_valid_in = '0;
                     rsp_done_in  = 1'b1;
                  end
                  FUNC_SPIKE: begin
                     state_in = S_DIV;
                  end
                  FUNC_READ: begin
                     rd_ok_in = (int'(req_payload.read_row) < MAX_OUT_ROWS)
                             && (int'(req_payload.read_col) < MAX_COLS)
                             && row_valid_ff[ORW'(req_payload.read_row)];
                     state_in = S_RDATA;
                  end
                  default: ;
               endcase
            end
         end

         S_DIV: begin
            if (div_done) begin
               rsp_in.acc_value = '0;
               if (div_rem >= wrows_cap) begin
                  // column check first: beyond the weight rows, ignore
                  rsp_in.status = STATUS_COL_IGNORED;
                  rsp_done_in   = 1'b1;
                  state_in      = S_IDLE;
               end else if (int'(div_quo) >= int'(orows_cap)) begin
                  rsp_in.status = STATUS_ROW_DROPPED;
                  rsp_done_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  rsp_in.status = STATUS_DONE;
                  abase_in      = AAW'(int'(div_quo) * MAX_COLS);
                  wbase_in      = WAW'(int'(div_rem) * MAX_COLS);
                  j_in          = '0;
                  ncols_in      = ncols_cap;
                  keep_in       = row_hit;
                  // a fresh row is swept whole so its unused words become zero
                  n_in          = row_hit ? CNW'(ncols_cap) : CNW'(MAX_COLS);
                  if (row_hit && (ncols_cap == 5'd0)) begin
                     rsp_done_in = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     row_valid_in[spike_row] = 1'b1;
                     state_in                = S_ACC;
                  end
               end
            end
         end

         S_ACC: begin
            // advance one accumulator word per cycle
            j_in = j_ff + CNW'(1);
            if (j_ff == (n_ff - CNW'(1))) begin
               state_in = S_DRAIN;
            end
         end

         S_DRAIN: begin
            // the last sum is written at this edge
            rsp_in.acc_value = '0;
            rsp_in.status    = STATUS_DONE;
            rsp_done_in      = 1'b1;
            state_in         = S_IDLE;
         end

         S_RDATA: begin
            rsp_in.acc_value = rd_ok_ff ? signed'(acc_q) : '0;
            rsp_in.status    = STATUS_DONE;
            rsp_done_in      = 1'b1;
            state_in         = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iw_ff        <= 7'd1;
         wrows_ff     <= 7'd64;
         wcols_ff     <= 5'd16;
         orows_ff     <= 5'd16;
         row_valid_ff <= '0;
         rsp_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iw_ff        <= iw_in;
         wrows_ff     <= wrows_in;
         wcols_ff     <= wcols_in;
         orows_ff     <= orows_in;
         row_valid_ff <= row_valid_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   // hold payload and loop bookkeeping without reset
   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok_in;
      abase_ff <= abase_in;
      wbase_ff <= wbase_in;
      j_ff     <= j_in;
      n_ff     <= n_in;
      ncols_ff <= ncols_in;
      keep_ff  <= keep_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_done    = rsp_done_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[tb/sv/sdwa_layer_checker.sv]
`timescale 1ns / 100ps
// Checker for the spike-driven weight accumulator: watches the item, result and register ports,
// keeps its own copy of the weights, accumulators and registers, and compares every result.
// Depends on sdwa_pkg for the payload types and the function, status and register codes.

module sdwa_layer_checker
   import sdwa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_payload,
   input  logic       rsp_done,
   input  rsp_type    rsp_payload,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata,
   output int         mismatches,
   output int         outstanding
);

   localparam int WT_ROWS  = 64;
   localparam int ACC_COLS = 16;
   localparam int ACC_ROWS = 16;

   logic [WORD_W-1:0] weight_words [WT_ROWS][ACC_COLS];
   logic [WORD_W-1:0] acc_words [ACC_ROWS][ACC_COLS];
   logic [6:0]        in_width;
   logic [6:0]        wt_rows_cfg;
   logic [4:0]        wt_cols_cfg;
   logic [4:0]        out_rows_cfg;
   rsp_type           owed_results [$];
   int                fault_total = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Apply one accepted item to the shadow state and return the result it must give.
   function automatic rsp_type layer_response(input req_type item);
      rsp_type     res;
      int unsigned divisor;
      int unsigned src_row;
      int unsigned src_col;
      int unsigned rows_lim;
      int unsigned outs_lim;
      int unsigned cols_lim;
      res = '0;
      res.status = STATUS_DONE;
      case (item.func)
         FUNC_WRITE_WEIGHT: begin
            weight_words[item.weight_row][item.weight_col] = item.weight_value;
         end
         FUNC_CLEAR: begin
            for (int r = 0; r < ACC_ROWS; r++)
               for (int c = 0; c < ACC_COLS; c++)
                  acc_words[r][c] = '0;
         end
         FUNC_SPIKE: begin
            divisor  = (in_width == 0) ? 1 : in_width;
            src_row  = item.spike_src / divisor;
            src_col  = item.spike_src % divisor;
            rows_lim = (wt_rows_cfg > WT_ROWS) ? WT_ROWS : wt_rows_cfg;
            outs_lim = (out_rows_cfg > ACC_ROWS) ? ACC_ROWS : out_rows_cfg;
            cols_lim = (wt_cols_cfg > ACC_COLS) ? ACC_COLS : wt_cols_cfg;
            // column check first: a spike out of both bounds counts as ignored
            if (src_col >= rows_lim)
               res.status = STATUS_COL_IGNORED;
            else if (src_row >= outs_lim)
               res.status = STATUS_ROW_DROPPED;
            else
               for (int j = 0; j < cols_lim; j++)
                  acc_words[src_row][j] = acc_words[src_row][j] + weight_words[src_col][j];
         end
         default: begin
            res.acc_value = acc_words[item.read_row][item.read_col];
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         in_width     = 7'd1;
         wt_rows_cfg  = 7'd64;
         wt_cols_cfg  = 5'd16;
         out_rows_cfg = 5'd16;
         for (int r = 0; r < ACC_ROWS; r++)
            for (int c = 0; c < ACC_COLS; c++)
               acc_words[r][c] = '0;
         for (int r = 0; r < WT_ROWS; r++)
            for (int c = 0; c < ACC_COLS; c++)
               weight_words[r][c] = '0;
         owed_results.delete();
      end else begin
         if (rsp_done) begin
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual acc_value %0d status %0d",
                        $time, rsp_payload.acc_value, rsp_payload.status);
               fault_total++;
            end else begin
               want = owed_results.pop_front();
               if (want.acc_value !== rsp_payload.acc_value) begin
                  $display("%0t: acc_value mismatch: expected %0d, actual %0d",
                           $time, want.acc_value, rsp_payload.acc_value);
                  fault_total++;
               end
               if (want.status !== rsp_payload.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_payload.status);
                  fault_total++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_INPUT_WIDTH:      in_width     = csr_wdata;
               CSR_WEIGHT_ROWS_USED: wt_rows_cfg  = csr_wdata;
               CSR_WEIGHT_COLS_USED: wt_cols_cfg  = csr_wdata[4:0];
               default:              out_rows_cfg = csr_wdata[4:0];
            endcase
         end
         if (start && !busy)
            owed_results.push_back(layer_response(req_payload));
      end
      outstanding <= owed_results.size();
      mismatches  <= fault_total;
   end

endmodule

[tb/sv/spike_driven_weight_accumulator_tb.sv]
`timescale 1ns / 100ps
// Top of the spike-driven weight accumulator testbench: clock, reset, item and register stimulus,
// watchdog and verdict. Depends on sdwa_pkg, the block and sdwa_layer_checker.

module spike_driven_weight_accumulator_tb;
   import sdwa_pkg::*;

   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 140;
   localparam int DRAIN_CYCLES = 40;
   // above the worst stall: the longest drawn gap plus a full-width first spike into a row
   localparam int STALL_LIMIT  = 2000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_payload;
   logic       rsp_done;
   rsp_type    rsp_payload;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [6:0] csr_wdata;
   int         mismatches;
   int         outstanding;

   // stimulus-side view of the registers and of which weight words hold data
   int unsigned cfg_width;
   int unsigned cfg_wt_rows;
   int unsigned cfg_wt_cols;
   int unsigned cfg_out_rows;
   logic [15:0] loaded_words [64];
   int          pace_mode;
   int          idle_cycles;
   int          n_writes, n_clears, spike_count, n_reads, n_settings;

   spike_driven_weight_accumulator u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_done    (rsp_done),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   sdwa_layer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_done    (rsp_done),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Reset the idle count on any transfer; give up once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_done || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results still owed",
                  $time, idle_cycles, outstanding);
         $display("spike_driven_weight_accumulator_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Fill every field with noise so unused fields toggle too; callers then set what matters.
   function automatic req_type fresh_item(input logic [1:0] func);
      logic [63:0] noise;
      req_type     item;
      noise = {$urandom, $urandom};
      item = req_type'(noise[$bits(req_type)-1:0]);
      item.func = func;
      return item;
   endfunction

   function automatic logic [31:0] weight_pattern();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // A spike is safe unless it would add a weight word that was never loaded.
   function automatic bit spike_safe(input int unsigned id);
      int unsigned divisor, src_row, src_col, rows_lim, outs_lim, cols_lim;
      divisor  = (cfg_width == 0) ? 1 : cfg_width;
      src_row  = id / divisor;
      src_col  = id % divisor;
      rows_lim = (cfg_wt_rows > 64) ? 64 : cfg_wt_rows;
      outs_lim = (cfg_out_rows > 16) ? 16 : cfg_out_rows;
      cols_lim = (cfg_wt_cols > 16) ? 16 : cfg_wt_cols;
      if (src_col >= rows_lim || src_row >= outs_lim)
         return 1'b1;
      for (int j = 0; j < cols_lim; j++)
         if (!loaded_words[src_col][j])
            return 1'b0;
      return 1'b1;
   endfunction

   // Offer one item after a drawn gap and hold it until the transfer happens.
   task automatic send_item(input req_type item);
      int gap;
      case (pace_mode)
         0:       gap = 0;
         1:       gap = $urandom_range(0, 10);
         default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      case (item.func)
         FUNC_WRITE_WEIGHT: begin
            n_writes++;
            loaded_words[item.weight_row][item.weight_col] = 1'b1;
         end
         FUNC_CLEAR: n_clears++;
         FUNC_SPIKE: spike_count++;
         default:    n_reads++;
      endcase
   endtask

   // Drop start and hold off until every owed result has come back.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_layer(input int unsigned width, input int unsigned wt_rows,
                            input int unsigned wt_cols, input int unsigned out_rows);
      logic [1:0] junk;
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_INPUT_WIDTH;
      csr_wdata <= width[6:0];
      @(posedge clock);
      csr_index <= CSR_WEIGHT_ROWS_USED;
      csr_wdata <= wt_rows[6:0];
      @(posedge clock);
      // the narrow registers ignore the top bits: toggle them anyway
      junk = 2'($urandom_range(0, 3));
      csr_index <= CSR_WEIGHT_COLS_USED;
      csr_wdata <= {junk, wt_cols[4:0]};
      @(posedge clock);
      junk = 2'($urandom_range(0, 3));
      csr_index <= CSR_OUTPUT_ROWS_USED;
      csr_wdata <= {junk, out_rows[4:0]};
      @(posedge clock);
      csr_we       <= 1'b0;
      cfg_width    = width & 127;
      cfg_wt_rows  = wt_rows & 127;
      cfg_wt_cols  = wt_cols & 31;
      cfg_out_rows = out_rows & 31;
      n_settings++;
   endtask

   task automatic load_weight(input int unsigned row, input int unsigned col,
                              input logic [31:0] value);
      req_type item;
      item = fresh_item(FUNC_WRITE_WEIGHT);
      item.weight_row   = row[5:0];
      item.weight_col   = col[3:0];
      item.weight_value = value;
      send_item(item);
   endtask

   task automatic fire_spike(input int unsigned id);
      req_type item;
      item = fresh_item(FUNC_SPIKE);
      item.spike_src = id[9:0];
      send_item(item);
   endtask

   task automatic read_acc(input int unsigned row, input int unsigned col);
      req_type item;
      item = fresh_item(FUNC_READ);
      item.read_row = row[3:0];
      item.read_col = col[3:0];
      send_item(item);
   endtask

   // One random item: mostly spikes that land inside the layer, with loads, reads and
   // clears around them; a spike that would hit an unloaded weight loads that word instead.
   task automatic random_item();
      int unsigned divisor, rows_lim, outs_lim, cols_lim, reach;
      int unsigned pick, id, src_col, row_sel;
      req_type     item;
      divisor  = (cfg_width == 0) ? 1 : cfg_width;
      rows_lim = (cfg_wt_rows > 64) ? 64 : cfg_wt_rows;
      outs_lim = (cfg_out_rows > 16) ? 16 : cfg_out_rows;
      cols_lim = (cfg_wt_cols > 16) ? 16 : cfg_wt_cols;
      reach    = (rows_lim < divisor) ? rows_lim : divisor;
      pick     = $urandom_range(0, 99);
      if (pick < 20) begin
         item = fresh_item(FUNC_WRITE_WEIGHT);
         if (rows_lim > 0 && $urandom_range(0, 3) != 0)
            item.weight_row = 6'($urandom_range(0, rows_lim - 1));
         item.weight_value = weight_pattern();
         send_item(item);
      end else if (pick < 24) begin
         send_item(fresh_item(FUNC_CLEAR));
      end else if (pick < 74) begin
         id = $urandom_range(0, 1023);
         if ($urandom_range(0, 4) != 0 && outs_lim > 0 && reach > 0) begin
            row_sel = $urandom_range(0, outs_lim - 1) * divisor + $urandom_range(0, reach - 1);
            if (row_sel <= 1023)
               id = row_sel;
         end
         if (spike_safe(id)) begin
            fire_spike(id);
         end else begin
            src_col = id % divisor;
            for (int j = 0; j < cols_lim; j++)
               if (!loaded_words[src_col][j]) begin
                  load_weight(src_col, j, weight_pattern());
                  break;
               end
         end
      end else begin
         item = fresh_item(FUNC_READ);
         if ($urandom_range(0, 3) != 0) begin
            item.read_row = (outs_lim > 0) ? 4'($urandom_range(0, outs_lim - 1)) : 4'd0;
            item.read_col = (cols_lim > 0) ? 4'($urandom_range(0, cols_lim - 1)) : 4'd0;
         end
         send_item(item);
      end
      if ($urandom_range(0, 99) == 0)
         wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_INPUT_WIDTH;
      csr_wdata   = '0;
      pace_mode   = 1;
      idle_cycles = 0;
      n_writes = 0; n_clears = 0; spike_count = 0; n_reads = 0; n_settings = 0;
      for (int r = 0; r < 64; r++)
         loaded_words[r] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: two ids per row, extreme weights so the sums wrap.
      set_layer(2, 64, 2, 16);
      load_weight(0, 0, 32'h7fff_ffff);
      load_weight(0, 1, 32'h8000_0000);
      load_weight(1, 0, 32'h0000_0001);
      load_weight(1, 1, 32'hffff_ffff);
      load_weight(63, 15, 32'ha5a5_5a5a);
      fire_spike(0);
      fire_spike(0);
      fire_spike(1);
      fire_spike(31);     // last accumulator row
      fire_spike(32);     // one row past the outputs: dropped
      fire_spike(1023);   // largest id: dropped
      read_acc(0, 0);
      read_acc(0, 1);
      read_acc(15, 1);
      read_acc(15, 15);   // beyond the used columns, inside the array
      send_item(fresh_item(FUNC_CLEAR));
      read_acc(0, 0);
      // one weight row: column 1 is ignored, also when the row is out of range too
      set_layer(2, 1, 2, 16);
      fire_spike(1);
      fire_spike(33);
      // all sizes zero, input width zero taken as one
      set_layer(0, 0, 0, 0);
      fire_spike(5);
      set_layer(1, 64, 0, 0);
      fire_spike(0);
      // no weight columns: the spike lands but adds nothing
      set_layer(1, 64, 0, 16);
      fire_spike(0);
      read_acc(0, 0);

      // Random phases, each under its own register setting and pacing.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_layer(64, 64, 16, 16);
            1: set_layer(127, 127, 31, 31);
            2: set_layer(1, 64, 16, 16);
            default: set_layer($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 127),
                               ($urandom_range(0, 2) != 0) ? $urandom_range(1, 8)
                                                           : $urandom_range(0, 127),
                               $urandom_range(0, 31), $urandom_range(0, 31));
         endcase
         pace_mode = phase % 3;
         for (int k = 0; k < PHASE_ITEMS; k++)
            random_item();
      end

      // Drain, then allow a spike's worth of cycles for anything stray.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items: %0d weight writes, %0d clears, %0d spikes, %0d reads",
               n_writes + n_clears + spike_count + n_reads, n_writes, n_clears, spike_count,
               n_reads);
      $display("under %0d register settings, with %0d mismatches", n_settings, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("spike_driven_weight_accumulator_tb: PASS");
      else
         $display("spike_driven_weight_accumulator_tb: FAIL");
      $finish;
   end

endmodule

[spike_driven_weight_accumulator.f]
rtl/sdwa_pkg.sv
rtl/sdwa_div.sv
rtl/sdwa_store.sv
rtl/spike_driven_weight_accumulator.sv
tb/sv/sdwa_layer_checker.sv
tb/sv/spike_driven_weight_accumulator_tb.sv
